[design/scvrb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scvrb_pkg
// Shared constants, types and the microcode table of the command value bank.
// ----------------------------------------------------------------------------
package scvrb_pkg;

    localparam int NUM_VALUES  = 4;
    localparam int BYTES_TOTAL = 4 * NUM_VALUES;
    localparam int CNT_W       = $clog2(BYTES_TOTAL);
    localparam int IDX_W       = (NUM_VALUES > 1) ? $clog2(NUM_VALUES) : 1;

    localparam logic [7:0] CH_READ  = 8'h72;  // 'r'
    localparam logic [7:0] CH_WRITE = 8'h77;  // 'w'
    localparam logic [7:0] CH_NEXT  = 8'h6E;  // 'n'

    // Microprogram step addresses.
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EMIT = 2'd1,
        ST_ERR  = 2'd2,
        ST_HALT = 2'd3
    } t_step;

    // What the datapath drives into the output register.
    typedef enum logic [1:0] {
        EM_NONE = 2'd0,
        EM_DATA = 2'd1,
        EM_ERR  = 2'd2
    } t_emit;

    // Jump conditions evaluated by the sequencer.
    typedef enum logic [1:0] {
        C_HOLD = 2'd0,  // stay on this step
        C_CMD  = 2'd1,  // dump start to tgt_a, load error to tgt_b
        C_EMIT = 2'd2,  // final dump byte stored to tgt_a
        C_SENT = 2'd3   // any result stored to tgt_a
    } t_cond;

    typedef struct packed {
        logic  accept;
        t_emit emit;
        t_cond cond;
        t_step tgt_a;
        t_step tgt_b;
    } t_ctl;

    typedef struct packed {
        logic go_dump;
        logic go_err;
        logic emit_fire;
        logic emit_last;
    } t_flags;

    function automatic t_ctl ucode(input t_step step);
        t_ctl w;
        case (step)
            ST_IDLE: w = '{accept: 1'b1, emit: EM_NONE, cond: C_CMD,
                           tgt_a: ST_EMIT, tgt_b: ST_ERR};
            ST_EMIT: w = '{accept: 1'b0, emit: EM_DATA, cond: C_EMIT,
                           tgt_a: ST_IDLE, tgt_b: ST_EMIT};
            ST_ERR:  w = '{accept: 1'b0, emit: EM_ERR, cond: C_SENT,
                           tgt_a: ST_HALT, tgt_b: ST_ERR};
            ST_HALT: w = '{accept: 1'b0, emit: EM_NONE, cond: C_HOLD,
                           tgt_a: ST_HALT, tgt_b: ST_HALT};
            default: w = '{accept: 1'b0, emit: EM_NONE, cond: C_HOLD,
                           tgt_a: ST_HALT, tgt_b: ST_HALT};
        endcase
        return w;
    endfunction

    // Power-up contents of the value words: 1.0, 1.5, 2.0, 2.5, then zero.
    function automatic logic [31:0] reset_word(input int idx);
        logic [31:0] v;
        case (idx)
            0:       v = 32'h3F80_0000;
            1:       v = 32'h3FC0_0000;
            2:       v = 32'h4000_0000;
            3:       v = 32'h4020_0000;
            default: v = 32'h0000_0000;
        endcase
        return v;
    endfunction

endpackage

[design/scvrb_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scvrb_seq
// Step counter and microcode table; selects the next step from the flags.
// ----------------------------------------------------------------------------
module scvrb_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  scvrb_pkg::t_flags    i_flags,
    output scvrb_pkg::t_ctl      o_ctl
);

    scvrb_pkg::t_step r_step;
    scvrb_pkg::t_step n_step;
    scvrb_pkg::t_ctl  w_ctl;

    assign w_ctl = scvrb_pkg::ucode(r_step);
    assign o_ctl = w_ctl;

    always_comb begin
        n_step = r_step;
        case (w_ctl.cond)
            scvrb_pkg::C_HOLD: n_step = r_step;
            scvrb_pkg::C_CMD: begin
                if (i_flags.go_dump) begin
                    n_step = w_ctl.tgt_a;
                end else if (i_flags.go_err) begin
                    n_step = w_ctl.tgt_b;
                end
            end
            scvrb_pkg::C_EMIT: begin
                if (i_flags.emit_fire && i_flags.emit_last) begin
                    n_step = w_ctl.tgt_a;
                end
            end
            scvrb_pkg::C_SENT: begin
                if (i_flags.emit_fire) begin
                    n_step = w_ctl.tgt_a;
                end
            end
            default: n_step = r_step;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= scvrb_pkg::ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

[design/scvrb_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scvrb_datapath
// Mode register, load assembly, value words and the output register.
// ----------------------------------------------------------------------------
module scvrb_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  scvrb_pkg::t_ctl      i_ctl,
    output scvrb_pkg::t_flags    o_flags,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [7:0]           i_s_tdata,
    input  logic                 i_s_tuser,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [7:0]           o_m_tdata,
    output logic                 o_m_tuser,
    output logic                 o_m_tlast
);

    typedef enum logic [2:0] {
        M_HOME  = 3'd0,
        M_READ  = 3'd1,
        M_WRITE = 3'd2,
        M_LOAD  = 3'd3,
        M_HALT  = 3'd4
    } t_mode;

    t_mode                          r_mode;
    logic [scvrb_pkg::CNT_W-1:0]    r_load_cnt;
    logic [23:0]                    r_partial;
    logic [31:0]                    r_store [scvrb_pkg::NUM_VALUES];
    logic [scvrb_pkg::CNT_W-1:0]    r_emit_cnt;
    logic                           r_ov;
    logic [7:0]                     r_obyte;
    logic                           r_ostat;
    logic                           r_olast;

    logic                           w_in_fire;
    logic                           w_emit_fire;
    logic                           w_emit_last;
    logic [scvrb_pkg::IDX_W-1:0]    w_rd_idx;
    logic [scvrb_pkg::IDX_W-1:0]    w_wr_idx;
    logic [31:0]                    w_rd_word;
    logic [7:0]                     w_rd_byte;

    assign o_s_tready  = i_ctl.accept;
    assign w_in_fire   = i_s_tvalid && i_ctl.accept;
    assign w_emit_fire = (i_ctl.emit != scvrb_pkg::EM_NONE) && (!r_ov || i_m_tready);
    assign w_emit_last = (r_emit_cnt == scvrb_pkg::CNT_W'(scvrb_pkg::BYTES_TOTAL - 1));

    assign w_rd_idx  = scvrb_pkg::IDX_W'(r_emit_cnt >> 2);
    assign w_wr_idx  = scvrb_pkg::IDX_W'(r_load_cnt >> 2);
    assign w_rd_word = r_store[w_rd_idx];

    // Most significant byte of each word goes out first.
    always_comb begin
        case (r_emit_cnt[1:0])
            2'd0:    w_rd_byte = w_rd_word[31:24];
            2'd1:    w_rd_byte = w_rd_word[23:16];
            2'd2:    w_rd_byte = w_rd_word[15:8];
            default: w_rd_byte = w_rd_word[7:0];
        endcase
    end

    assign o_flags.go_dump   = w_in_fire && (r_mode == M_READ) &&
                               (i_s_tdata == scvrb_pkg::CH_NEXT);
    assign o_flags.go_err    = w_in_fire && (r_mode == M_LOAD) && i_s_tuser;
    assign o_flags.emit_fire = w_emit_fire;
    assign o_flags.emit_last = w_emit_last;

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_obyte;
    assign o_m_tuser  = r_ostat;
    assign o_m_tlast  = r_olast;

    // Command decode and load assembly.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= M_HOME;
            r_load_cnt <= '0;
            r_partial  <= '0;
            for (int i = 0; i < scvrb_pkg::NUM_VALUES; i++) begin
                r_store[i] <= scvrb_pkg::reset_word(i);
            end
        end else if (w_in_fire) begin
            case (r_mode)
                M_HOME: begin
                    if (i_s_tdata == scvrb_pkg::CH_READ) begin
                        r_mode <= M_READ;
                    end else if (i_s_tdata == scvrb_pkg::CH_WRITE) begin
                        r_mode <= M_WRITE;
                    end
                end
                M_READ: begin
                    if (i_s_tdata != scvrb_pkg::CH_NEXT) begin
                        r_mode <= M_HOME;
                    end
                end
                M_WRITE: begin
                    if (i_s_tdata == scvrb_pkg::CH_WRITE) begin
                        r_mode     <= M_LOAD;
                        r_load_cnt <= '0;
                        r_partial  <= '0;
                    end else begin
                        r_mode <= M_HOME;
                    end
                end
                M_LOAD: begin
                    if (i_s_tuser) begin
                        r_mode <= M_HALT;
                    end else begin
                        if (r_load_cnt[1:0] == 2'd3) begin
                            r_store[w_wr_idx] <= {r_partial, i_s_tdata};
                            r_partial         <= '0;
                        end else begin
                            r_partial <= {r_partial[15:0], i_s_tdata};
                        end
                        if (r_load_cnt ==
                            scvrb_pkg::CNT_W'(scvrb_pkg::BYTES_TOTAL - 1)) begin
                            r_load_cnt <= '0;
                            r_mode     <= M_WRITE;
                        end else begin
                            r_load_cnt <= r_load_cnt + 1'b1;
                        end
                    end
                end
                default: r_mode <= r_mode;
            endcase
        end
    end

    // Output register and dump byte counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov       <= 1'b0;
            r_emit_cnt <= '0;
        end else begin
            if (w_emit_fire) begin
                r_ov <= 1'b1;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
            if (w_emit_fire && (i_ctl.emit == scvrb_pkg::EM_DATA)) begin
                if (w_emit_last) begin
                    r_emit_cnt <= '0;
                end else begin
                    r_emit_cnt <= r_emit_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit_fire) begin
            if (i_ctl.emit == scvrb_pkg::EM_ERR) begin
                r_obyte <= 8'h00;
                r_ostat <= 1'b1;
                r_olast <= 1'b1;
            end else begin
                r_obyte <= w_rd_byte;
                r_ostat <= 1'b0;
                r_olast <= w_emit_last;
            end
        end
    end

    // A new input never arrives while a result is being produced.
    a_no_accept_while_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |-> (i_ctl.emit == scvrb_pkg::EM_NONE))
        else $error("input accepted during result generation");

    // A dump always starts from the first byte of the first word.
    a_dump_starts_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_flags.go_dump |-> (r_emit_cnt == '0))
        else $error("dump started with a nonzero byte counter");

    // The error result is always the final one of its request.
    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_ostat) |-> r_olast)
        else $error("error result without last");

    // Once halted, the block takes no further input.
    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == M_HALT) |-> !o_s_tready)
        else $error("input ready while halted");

endmodule

[design/serial_command_value_register_bank_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_command_value_register_bank_top
// Serial command decoder holding four 32-bit value words.
// ----------------------------------------------------------------------------
// Each input request carries one received byte (tdata) and the receiver's
// error flag (tuser). The block walks between home, read, write and loading
// modes: 'r' or 'w' in home selects read or write, 'n' in read sends all
// value words as bytes with the most significant byte first, 'w' in write
// loads the next sixteen bytes into the words, and any other command byte
// falls back to home. After its 'n' is taken, a dump holds the input while
// the sixteen bytes pass one per handshake through the byte-wide output,
// and it stalls while a full output register waits for tready. No input
// is taken until the last byte has entered the output register. An error
// flag on a loading byte yields one status result and halts the block until
// reset. After reset the words hold 1.0, 1.5, 2.0 and 2.5 as single-precision
// bit patterns.
// ----------------------------------------------------------------------------
module serial_command_value_register_bank_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Received byte requests.
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] rx_byte
    input  logic       i_s_tuser,   // [0] rx_error
    // Transmit byte requests.
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] tx_byte
    output logic       o_m_tuser,   // [0] status: 1 means receive error, halted
    output logic       o_m_tlast    // last result of the input request
);

    scvrb_pkg::t_ctl   w_ctl;
    scvrb_pkg::t_flags w_flags;

    // The sequencer steps through a four-word microprogram: wait for a
    // command, stream the dump, send the error status, or stay halted.
    scvrb_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_ctl   (w_ctl)
    );

    // The datapath decodes bytes, assembles loaded words and owns the
    // output register, so a finished result can wait while input continues.
    scvrb_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .o_flags    (w_flags),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the serial command value register bank.
// ----------------------------------------------------------------------------
// Received bytes are sent as input requests. A behavioral copy of the bank
// follows every accepted byte and queues the transmit bytes that the byte
// should cause. Each transmit request that the block hands over is checked
// against the oldest queued byte. A short table of hand-picked bytes runs
// first. Three random phases follow, mostly well-formed read and write
// sequences, with different idle patterns on the two sides. The run closes
// with a receive error on a loading byte, which halts the block for good.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int         CLK_HALF   = 4;
    localparam int         CYCLE_CAP  = 400000;
    localparam int         QUIET_WAIT = 40;
    localparam int         DUMP_LEN   = 4 * scvrb_pkg::NUM_VALUES;
    localparam logic [7:0] CH_BACK    = 8'h62;   // 'b'

    // Dump of the value words as they come out of reset, first byte on top.
    localparam logic [127:0] RESET_DUMP =
        128'h3F80_0000_3FC0_0000_4000_0000_4020_0000;

    typedef enum logic [2:0] {
        MODE_HOME,
        MODE_READ,
        MODE_WRITE,
        MODE_LOAD,
        MODE_HALT
    } t_bank_mode;

    // How a table row gets its expected transmit bytes.
    typedef enum logic [1:0] {
        ROW_PREDICT,     // from the behavioral bank
        ROW_QUIET,       // the byte causes nothing
        ROW_RESET_DUMP,  // the sixteen power-up bytes
        ROW_HALT         // the single receive-error status
    } t_row_kind;

    typedef struct packed {
        logic [7:0] data;
        logic       err;
        t_row_kind  kind;
    } t_stim_row;

    typedef struct packed {
        logic [7:0] tx;
        logic       status;
        logic       last;
    } t_tx_item;

    localparam int TAIL_FROM = 29;
    localparam int ROW_COUNT = 37;

    // Rows up to TAIL_FROM run right after reset; the rest close the run,
    // since the receive error in the last row stops the block until reset.
    t_stim_row dir_rows [0:ROW_COUNT-1] = '{
        '{scvrb_pkg::CH_NEXT,  1'b0, ROW_QUIET},    // 'n' in home is ignored
        '{scvrb_pkg::CH_READ,  1'b1, ROW_QUIET},    // error on a command byte is ignored
        '{scvrb_pkg::CH_NEXT,  1'b0, ROW_RESET_DUMP},
        '{CH_BACK,             1'b0, ROW_QUIET},    // read back to home
        '{scvrb_pkg::CH_WRITE, 1'b0, ROW_QUIET},
        '{8'h00,               1'b1, ROW_QUIET},    // write back to home
        '{scvrb_pkg::CH_WRITE, 1'b0, ROW_QUIET},
        '{scvrb_pkg::CH_WRITE, 1'b1, ROW_QUIET},    // start of a load
        '{8'hFF,               1'b0, ROW_QUIET},
        '{8'h00,               1'b0, ROW_QUIET},
        '{scvrb_pkg::CH_READ,  1'b0, ROW_QUIET},
        '{scvrb_pkg::CH_WRITE, 1'b0, ROW_QUIET},
        '{scvrb_pkg::CH_NEXT,  1'b0, ROW_QUIET},
        '{CH_BACK,             1'b0, ROW_QUIET},
        '{8'h80,               1'b0, ROW_QUIET},
        '{8'h01,               1'b0, ROW_QUIET},
        '{8'h7F,               1'b0, ROW_QUIET},
        '{8'hFE,               1'b0, ROW_QUIET},
        '{8'h55,               1'b0, ROW_QUIET},
        '{8'hAA,               1'b0, ROW_QUIET},
        '{8'h12,               1'b0, ROW_QUIET},
        '{8'h34,               1'b0, ROW_QUIET},
        '{8'h56,               1'b0, ROW_QUIET},
        '{8'h78,               1'b0, ROW_QUIET},    // last loading byte, back to write
        '{scvrb_pkg::CH_NEXT,  1'b0, ROW_QUIET},    // 'n' in write goes home
        '{scvrb_pkg::CH_READ,  1'b0, ROW_QUIET},
        '{scvrb_pkg::CH_NEXT,  1'b0, ROW_PREDICT},  // dump of the freshly loaded words
        '{scvrb_pkg::CH_NEXT,  1'b1, ROW_PREDICT},
        '{8'hFF,               1'b0, ROW_QUIET},
        // Closing sequence.
        '{scvrb_pkg::CH_WRITE, 1'b0, ROW_QUIET},
        '{scvrb_pkg::CH_WRITE, 1'b0, ROW_QUIET},
        '{8'hDE,               1'b0, ROW_QUIET},
        '{8'hAD,               1'b0, ROW_QUIET},
        '{8'hBE,               1'b0, ROW_QUIET},
        '{8'hEF,               1'b0, ROW_QUIET},    // first word complete
        '{8'h11,               1'b0, ROW_QUIET},
        '{8'hC3,               1'b1, ROW_HALT}      // receive error while loading
    };

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       s_tvalid  = 1'b0;
    logic [7:0] s_tdata   = 8'h00;
    logic       s_tuser   = 1'b0;
    logic       m_tready  = 1'b0;
    logic       o_s_tready;
    logic       o_m_tvalid;
    logic [7:0] o_m_tdata;
    logic       o_m_tuser;
    logic       o_m_tlast;

    // Idle chance per cycle, in percent, for each side.
    int src_idle_pct = 0;
    int rx_idle_pct  = 0;

    int cycle_count    = 0;
    int mismatch_count = 0;

    // Behavioral bank state.
    t_bank_mode  bank_mode;
    int          load_count;
    logic [23:0] load_partial;
    logic [31:0] bank_words [scvrb_pkg::NUM_VALUES];

    // Transmit bytes caused by the latest byte, and all bytes still owed.
    t_tx_item reply_bytes [DUMP_LEN];
    int       reply_count;
    t_tx_item tx_expected_q [$];

    serial_command_value_register_bank_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Hard stop in case the block stops talking.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // The receiver side stalls at random according to the current phase.
    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Works out the transmit bytes for one received byte and steps the
    // behavioral bank along.
    function automatic void predict_bank_reply(input logic [7:0] rx, input logic err);
        int w;
        int s;
        reply_count = 0;
        case (bank_mode)
            MODE_HOME: begin
                if (rx == scvrb_pkg::CH_READ)
                    bank_mode = MODE_READ;
                else if (rx == scvrb_pkg::CH_WRITE)
                    bank_mode = MODE_WRITE;
            end
            MODE_READ: begin
                if (rx == scvrb_pkg::CH_NEXT) begin
                    for (w = 0; w < scvrb_pkg::NUM_VALUES; w++) begin
                        for (s = 0; s < 4; s++) begin
                            reply_bytes[reply_count] = '{
                                tx:     bank_words[w][8*(3-s) +: 8],
                                status: 1'b0,
                                last:   (reply_count == DUMP_LEN - 1)};
                            reply_count++;
                        end
                    end
                end else begin
                    bank_mode = MODE_HOME;
                end
            end
            MODE_WRITE: begin
                if (rx == scvrb_pkg::CH_WRITE) begin
                    bank_mode    = MODE_LOAD;
                    load_count   = 0;
                    load_partial = '0;
                end else begin
                    bank_mode = MODE_HOME;
                end
            end
            MODE_LOAD: begin
                if (err) begin
                    // The word in progress is dropped; the block goes silent.
                    bank_mode      = MODE_HALT;
                    reply_bytes[0] = '{tx: 8'h00, status: 1'b1, last: 1'b1};
                    reply_count    = 1;
                end else begin
                    if ((load_count % 4) == 3) begin
                        bank_words[load_count / 4] = {load_partial, rx};
                        load_partial = '0;
                    end else begin
                        load_partial = {load_partial[15:0], rx};
                    end
                    load_count++;
                    if (load_count >= DUMP_LEN) begin
                        load_count = 0;
                        bank_mode  = MODE_WRITE;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // Offers one byte, waits for it to be taken and queues what it owes.
    task automatic send_request(input logic [7:0] data, input logic err,
                                input t_row_kind kind);
        int k;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= err;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);

        // The byte was taken at this edge. The behavioral bank always steps,
        // even where the expected bytes are typed into the table.
        predict_bank_reply(data, err);
        case (kind)
            ROW_PREDICT: begin
                for (k = 0; k < reply_count; k++)
                    tx_expected_q.push_back(reply_bytes[k]);
            end
            ROW_RESET_DUMP: begin
                for (k = 0; k < DUMP_LEN; k++)
                    tx_expected_q.push_back('{tx: RESET_DUMP[127 - 8*k -: 8],
                                              status: 1'b0,
                                              last: (k == DUMP_LEN - 1)});
            end
            ROW_HALT: tx_expected_q.push_back('{tx: 8'h00, status: 1'b1, last: 1'b1});
            default: ;
        endcase
    endtask

    // Random traffic that mostly follows the command protocol. Bytes that
    // home simply drops do not count toward the requested number.
    task automatic run_random_phase(input int wanted);
        int         taken;
        int         pick;
        logic [7:0] data;
        logic       err;
        taken = 0;
        while (taken < wanted) begin
            pick = $urandom_range(99);
            data = 8'($urandom_range(255));
            err  = ($urandom_range(3) == 0);
            case (bank_mode)
                MODE_HOME: begin
                    if (pick < 45)
                        data = scvrb_pkg::CH_READ;
                    else if (pick < 80)
                        data = scvrb_pkg::CH_WRITE;
                end
                MODE_READ: begin
                    if (pick < 65)
                        data = scvrb_pkg::CH_NEXT;
                    else if (pick < 75)
                        data = CH_BACK;
                end
                MODE_WRITE: begin
                    if (pick < 65)
                        data = scvrb_pkg::CH_WRITE;
                    else if (pick < 75)
                        data = CH_BACK;
                end
                default: err = 1'b0;   // an error while loading would halt
            endcase
            if (bank_mode != MODE_HOME || data == scvrb_pkg::CH_READ ||
                data == scvrb_pkg::CH_WRITE)
                taken++;
            send_request(data, err, ROW_PREDICT);
        end
    endtask

    // Every transmit request is matched against the oldest owed byte.
    always @(posedge i_clk) begin
        t_tx_item want;
        if (i_rst_n && o_m_tvalid && m_tready) begin
            if (tx_expected_q.size() == 0) begin
                $error("unexpected transmit request: tx_byte %0h status %0b last %0b",
                       o_m_tdata, o_m_tuser, o_m_tlast);
                mismatch_count++;
            end else begin
                want = tx_expected_q.pop_front();
                if (o_m_tdata !== want.tx) begin
                    $error("tx_byte: expected %0h, actual %0h", want.tx, o_m_tdata);
                    mismatch_count++;
                end
                if (o_m_tuser !== want.status) begin
                    $error("status: expected %0b, actual %0b", want.status, o_m_tuser);
                    mismatch_count++;
                end
                if (o_m_tlast !== want.last) begin
                    $error("last: expected %0b, actual %0b", want.last, o_m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        int r;
        bank_mode    = MODE_HOME;
        load_count   = 0;
        load_partial = '0;
        for (r = 0; r < scvrb_pkg::NUM_VALUES; r++)
            bank_words[r] = scvrb_pkg::reset_word(r);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Sender rarely idles while the receiver mostly stalls.
        src_idle_pct = 11;
        rx_idle_pct  = 85;
        for (r = 0; r < TAIL_FROM; r++)
            send_request(dir_rows[r].data, dir_rows[r].err, dir_rows[r].kind);
        run_random_phase(45);

        // Now the other way round, then full speed on both sides.
        src_idle_pct = 85;
        rx_idle_pct  = 11;
        run_random_phase(45);
        src_idle_pct = 0;
        rx_idle_pct  = 0;
        run_random_phase(45);

        // Bring the bank back home so the closing rows start from a known
        // mode; a load in progress is finished with clean bytes.
        while (bank_mode != MODE_HOME) begin
            if (bank_mode == MODE_LOAD)
                send_request(8'($urandom_range(255)), 1'b0, ROW_PREDICT);
            else
                send_request(CH_BACK, 1'($urandom_range(1)), ROW_PREDICT);
        end
        for (r = TAIL_FROM; r < ROW_COUNT; r++)
            send_request(dir_rows[r].data, dir_rows[r].err, dir_rows[r].kind);
        s_tvalid <= 1'b0;

        while (tx_expected_q.size() != 0)
            @(posedge i_clk);
        // Anything the block sends after this point is flagged by the checker.
        repeat (QUIET_WAIT) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
